// File: rtl/oriented_face_cancel_table_macros.svh
// Assertion macros for the oriented face cancel table.
// Included by the top level; depends on nothing else.
`ifndef ORIENTED_FACE_CANCEL_TABLE_MACROS_SVH
`define ORIENTED_FACE_CANCEL_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OFCT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define OFCT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ofct_pkg.sv
// Shared types and constants of the oriented face cancel table.
// Used by the channel interfaces and the top level; depends on nothing.
package ofct_pkg;

   localparam int NODE_W   = 20;
   localparam int FSIZE_W  = 2;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;
   localparam int COUNT_W  = 9;

   typedef logic [NODE_W-1:0]   node_type;
   typedef logic [FSIZE_W-1:0]  fsize_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [COUNT_W-1:0]  count_type;

   localparam fsize_type EDGE_SIZE = FSIZE_W'(2);

   localparam status_type ST_ADDED  = STATUS_W'(0);
   localparam status_type ST_CANCEL = STATUS_W'(1);
   localparam status_type ST_DUP    = STATUS_W'(2);
   localparam status_type ST_FULL   = STATUS_W'(3);

endpackage

// File: rtl/ofct_channels.sv
// Valid/ready channel interfaces for face words, result words and the configuration word.
// Depends on ofct_pkg.
interface ofct_req_if import ofct_pkg::*; ();
   logic     valid;
   logic     ready;
   node_type node_a;
   node_type node_b;
   node_type node_c;
   modport source (output valid, output node_a, output node_b, output node_c, input ready);
   modport sink (input valid, input node_a, input node_b, input node_c, output ready);
endinterface

interface ofct_rsp_if import ofct_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   slot_type   slot;
   count_type  face_count;
   modport source (output valid, output status, output slot, output face_count, input ready);
   modport sink (input valid, input status, input slot, input face_count, output ready);
endinterface

interface ofct_csr_if import ofct_pkg::*; ();
   logic      valid;
   logic      ready;
   fsize_type face_size;
   modport source (output valid, output face_size, input ready);
   modport sink (input valid, input face_size, output ready);
endinterface

// File: rtl/ofct_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module ofct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/oriented_face_cancel_table.sv
// Channel   Dir  Handshake    Word
// req_ch    in   valid/ready  node_a, node_b, node_c
// rsp_ch    out  valid/ready  status, slot, face_count
// csr_ch    in   valid/ready  face_size
// An item is accepted, then checked against the face memory slot by slot (one
// read a cycle, stopping at the first match), then used to update the memories.
// After reset a clearing pass over every slot initializes the memories; no
// face word is accepted meanwhile. The result register lets the next word be
// accepted while a result waits; a stalled result holds the update step.
// Top level of the oriented face cancel table; depends on ofct_pkg, the channel
// interfaces, ofct_ram and the assertion macros.
`include "oriented_face_cancel_table_macros.svh"

module oriented_face_cancel_table import ofct_pkg::*; #(
   parameter int CAPACITY  = 256,
   parameter int NODE_BITS = 20
) (
   input logic         clock,
   input logic         reset,
   ofct_req_if.sink    req_ch,
   ofct_rsp_if.source  rsp_ch,
   ofct_csr_if.sink    csr_ch
);

   localparam int NB = (NODE_BITS < NODE_W) ? NODE_BITS : NODE_W;
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int FW = 3 * NB + 1;
   localparam logic [CW-1:0] NONE_SLOT = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_WRITE = 2'd3;

   logic [1:0]    state_ff, state_in;
   fsize_type     face_size_ff, face_size_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          hit_ff, hit_in;
   status_type    hit_status_ff, hit_status_in;
   logic [IW-1:0] hit_slot_ff, hit_slot_in;
   logic [CW-1:0] free_head_ff, free_head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NB-1:0] n0_ff, n0_in, n1_ff, n1_in, n2_ff, n2_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   slot_type      rsp_slot_ff, rsp_slot_in;
   count_type     rsp_count_ff, rsp_count_in;

   logic          face_wr_en, face_rd_en;
   logic [IW-1:0] face_wr_addr, face_rd_addr;
   logic [FW-1:0] face_wr_data, face_rd_data;
   logic          free_wr_en, free_rd_en;
   logic [IW-1:0] free_wr_addr, free_rd_addr;
   logic [CW-1:0] free_wr_data, free_rd_data;

   logic          tri_mode, accept, write_go, same_match, rev_match, face_live;
   logic [NB-1:0] f0, f1, f2;

   ofct_ram #(.WIDTH(FW), .DEPTH(CAPACITY)) u_face_ram (
      .clock   (clock),
      .wr_en   (face_wr_en),
      .wr_addr (face_wr_addr),
      .wr_data (face_wr_data),
      .rd_en   (face_rd_en),
      .rd_addr (face_rd_addr),
      .rd_data (face_rd_data)
   );

   ofct_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   assign tri_mode  = (face_size_ff != EDGE_SIZE);
   assign f0        = face_rd_data[NB-1:0];
   assign f1        = face_rd_data[2*NB-1:NB];
   assign f2        = face_rd_data[3*NB-1:2*NB];
   assign face_live = face_rd_data[FW-1];

   always_comb begin
      if (!tri_mode) begin
         same_match = (n0_ff == f0) && (n1_ff == f1);
         rev_match  = (n1_ff == f0) && (n0_ff == f1);
      end else begin
         same_match = ((n0_ff == f0) && (n1_ff == f1) && (n2_ff == f2)) ||
                      ((n1_ff == f0) && (n2_ff == f1) && (n0_ff == f2)) ||
                      ((n2_ff == f0) && (n0_ff == f1) && (n1_ff == f2));
         rev_match  = ((n2_ff == f0) && (n1_ff == f1) && (n0_ff == f2)) ||
                      ((n1_ff == f0) && (n0_ff == f1) && (n2_ff == f2)) ||
                      ((n0_ff == f0) && (n2_ff == f1) && (n1_ff == f2));
      end
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign write_go     = (state_ff == S_WRITE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.face_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      face_size_in  = face_size_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      hit_status_in = hit_status_ff;
      hit_slot_in   = hit_slot_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      n0_in         = n0_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      face_wr_en    = 1'b0;
      face_wr_addr  = cnt_ff;
      face_wr_data  = '0;
      face_rd_en    = 1'b0;
      face_rd_addr  = '0;
      free_wr_en    = 1'b0;
      free_wr_addr  = cnt_ff;
      free_wr_data  = free_head_ff;
      free_rd_en    = 1'b0;
      free_rd_addr  = free_head_ff[IW-1:0];

      if (csr_ch.valid && csr_ch.ready) begin
         face_size_in = csr_ch.face_size;
      end

      case (state_ff)
         S_CLEAR: begin
            // Every slot starts invalid and linked to its successor.
            face_wr_en   = 1'b1;
            free_wr_en   = 1'b1;
            free_wr_data = CW'(cnt_ff) + CW'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               n0_in      = req_ch.node_a[NB-1:0];
               n1_in      = req_ch.node_b[NB-1:0];
               n2_in      = tri_mode ? req_ch.node_c[NB-1:0] : '0;
               face_rd_en = 1'b1;
               free_rd_en = 1'b1;
               cnt_in     = '0;
               hit_in     = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (face_live && (same_match || rev_match)) begin
               hit_in        = 1'b1;
               hit_status_in = same_match ? ST_DUP : ST_CANCEL;
               hit_slot_in   = cnt_ff;
               state_in      = S_WRITE;
            end else if (cnt_ff == LAST_SLOT) begin
               state_in = S_WRITE;
            end else begin
               cnt_in       = cnt_ff + IW'(1);
               face_rd_en   = 1'b1;
               face_rd_addr = cnt_ff + IW'(1);
            end
         end
         S_WRITE: begin
            if (write_go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (hit_ff && (hit_status_ff == ST_CANCEL)) begin
                  face_wr_en    = 1'b1;
                  face_wr_addr  = hit_slot_ff;
                  free_wr_en    = 1'b1;
                  free_wr_addr  = hit_slot_ff;
                  free_wr_data  = free_head_ff;
                  free_head_in  = CW'(hit_slot_ff);
                  count_in      = (count_ff != '0) ? (count_ff - CW'(1)) : count_ff;
                  rsp_status_in = ST_CANCEL;
                  rsp_slot_in   = SLOT_W'(hit_slot_ff);
               end else if (hit_ff) begin
                  rsp_status_in = ST_DUP;
                  rsp_slot_in   = '0;
               end else if (free_head_ff != NONE_SLOT) begin
                  face_wr_en    = 1'b1;
                  face_wr_addr  = free_head_ff[IW-1:0];
                  face_wr_data  = {1'b1, n2_ff, n1_ff, n0_ff};
                  free_head_in  = free_rd_data;
                  count_in      = count_ff + CW'(1);
                  rsp_status_in = ST_ADDED;
                  rsp_slot_in   = SLOT_W'(free_head_ff);
               end else begin
                  rsp_status_in = ST_FULL;
                  rsp_slot_in   = '0;
               end
               rsp_count_in = COUNT_W'(count_in);
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         face_size_ff <= EDGE_SIZE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         free_head_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         face_size_ff <= face_size_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_status_ff <= hit_status_in;
      hit_slot_ff   <= hit_slot_in;
      n0_ff         <= n0_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `OFCT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "face count above capacity")
   `OFCT_ASSERT_NXT(a_cancel_push, clock, reset, write_go && hit_ff && (hit_status_ff == ST_CANCEL), free_head_ff == CW'($past(hit_slot_ff)), "cancelled slot not at free list head")
   `OFCT_ASSERT_NXT(a_add_count, clock, reset, write_go && !hit_ff && (free_head_ff != NONE_SLOT), count_ff == $past(count_ff) + CW'(1), "added face did not raise the count")

endmodule
